[rtl/rfr_pkg.sv]
`timescale 1ns / 1ps

package rfr_pkg;

    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int DIM_W       = 7;
    localparam int POS_W       = 6;
    localparam int PIX_W       = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int DIV_CNT_W   = $clog2(ADDR_W);

    // request codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION = 2'd3;

    // rotation codes
    localparam logic [1:0] ROT_NONE = 2'd0;
    localparam logic [1:0] ROT_CW   = 2'd1;
    localparam logic [1:0] ROT_HALF = 2'd2;
    localparam logic [1:0] ROT_CCW  = 2'd3;

    typedef struct packed {
        logic              start;
        logic [ADDR_W-1:0] dividend;
        logic [DIM_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] quot;
        logic [POS_W-1:0] rem;
    } div_rsp_t;

endpackage

[rtl/rfr_store.sv]
`timescale 1ns / 1ps

module rfr_store
    import rfr_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [PIX_W-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [PIX_W-1:0]  rd_data
);

    logic [PIX_W-1:0] mem [STORE_DEPTH];
    logic [PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/rfr_divider.sv]
`timescale 1ns / 1ps

module rfr_divider
    import rfr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [ADDR_W-1:0]    quo_reg, quo_next;
    logic [POS_W-1:0]     rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [DIM_W-1:0]     trial;
    logic                 fits;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, quo_reg[ADDR_W-1]};
    assign fits  = (trial >= req.divisor);

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next = req.dividend;
            rem_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            quo_next = {quo_reg[ADDR_W-2:0], fits};
            rem_next = fits ? POS_W'(trial - req.divisor) : trial[POS_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(ADDR_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg[POS_W-1:0];
    assign rsp.rem  = rem_reg;

endmodule

[rtl/rgb_frame_rotator_unit.sv]
// rgb frame rotator: frame store that turns an rgb24 frame by 0, 90, 180 or 270 degrees
// input channel: start/busy; a word is taken at a clock edge with start high and busy low
//   req_type load writes pixel_in at the next raster position of the source frame
//   (loads past a full frame are dropped); req_type fetch asks for the next output pixel
// result channel: result_valid strobes one cycle with pixel_out, last_pixel, early;
//   the receiver cannot stall, results are never held
// a fetch's result is registered and shows in the cycle after the fetch is taken
// throughput: one word per cycle while busy is low, loads and fetches alike, bounded
//   by the one write port and one read port of the frame store
// after a configuration write busy stays high while the sequential divider rebuilds
//   the output row and column from the fetch count (one bit per cycle)
// config channel: cfg_valid/cfg_ready, always ready; index 0 width, 1 height,
//   2 vertical flip, 3 rotation
// reset: counters clear, width and height 64, no flip, no rotation; the frame store
//   holds nothing useful until loaded, no clearing pass
// a fetch before the whole frame is loaded returns early with a zero pixel
`timescale 1ns / 1ps

module rgb_frame_rotator_unit
    import rfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 req_type,
    input  logic [PIX_W-1:0]     pixel_in,
    output logic                 result_valid,
    output logic [PIX_W-1:0]     pixel_out,
    output logic                 last_pixel,
    output logic                 early,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    localparam logic [1:0] ST_RUN      = 2'd0;
    localparam logic [1:0] ST_DIV_LOAD = 2'd1;
    localparam logic [1:0] ST_DIV_WAIT = 2'd2;

    // configuration registers
    logic [DIM_W-1:0] width_reg, height_reg;
    logic             flip_reg;
    logic [1:0]       rot_reg;

    // control state
    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  load_cnt_reg, load_cnt_next;
    logic [ADDR_W-1:0] emit_cnt_reg, emit_cnt_next;
    logic [POS_W-1:0]  row_reg, row_next;
    logic [POS_W-1:0]  col_reg, col_next;
    logic              res_valid_reg;
    logic              res_early_reg;
    logic              res_last_reg;

    logic cfg_wr;
    logic accept;
    logic do_load;
    logic do_fetch;
    logic frame_full;
    logic is_last;

    logic [DIM_W-1:0]      w_eff, h_eff, out_w;
    logic [DIM_W-1:0]      w_m1, h_m1;
    logic [2*DIM_W-1:0]    total_full;
    logic [CNT_W-1:0]      total;
    logic [ADDR_W-1:0]     emit_eff;
    logic [DIM_W-1:0]      src_y, src_x, src_y_fl;
    logic [CNT_W-1:0]      addr_full;
    logic [ADDR_W-1:0]     rd_addr;
    logic [PIX_W-1:0]      rd_data;
    logic [DIM_W-1:0]      col_inc;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign busy      = (state_reg != ST_RUN);
    assign accept    = start && !busy;

    // clamp sizes to 1..max
    always_comb
    begin
        if (width_reg == '0)
            w_eff = DIM_W'(1);
        else if (width_reg > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    assign w_m1       = w_eff - 1'b1;
    assign h_m1       = h_eff - 1'b1;
    assign total_full = w_eff * h_eff;
    assign total      = total_full[CNT_W-1:0];
    assign out_w      = (rot_reg == ROT_CW || rot_reg == ROT_CCW) ? h_eff : w_eff;

    assign frame_full = (load_cnt_reg >= total);
    assign do_load    = accept && (req_type == REQ_LOAD);
    assign do_fetch   = accept && (req_type == REQ_FETCH);

    // a count left beyond the frame by a size change restarts at pixel zero
    assign emit_eff = ({1'b0, emit_cnt_reg} < total) ? emit_cnt_reg : '0;
    assign is_last  = (({1'b0, emit_eff} + 1'b1) >= total);

    // output row/column to source coordinates
    always_comb
    begin
        case (rot_reg)
            ROT_CW:
            begin
                src_y = h_m1 - {1'b0, col_reg};
                src_x = {1'b0, row_reg};
            end
            ROT_HALF:
            begin
                src_y = h_m1 - {1'b0, row_reg};
                src_x = w_m1 - {1'b0, col_reg};
            end
            ROT_CCW:
            begin
                src_y = {1'b0, col_reg};
                src_x = w_m1 - {1'b0, row_reg};
            end
            default:
            begin
                src_y = {1'b0, row_reg};
                src_x = {1'b0, col_reg};
            end
        endcase
    end

    assign src_y_fl  = flip_reg ? (h_m1 - src_y) : src_y;
    assign addr_full = CNT_W'(src_y_fl[POS_W-1:0] * w_eff) + CNT_W'(src_x[POS_W-1:0]);
    assign rd_addr   = addr_full[ADDR_W-1:0];
    assign col_inc   = {1'b0, col_reg} + 1'b1;

    // counters and sequencing
    always_comb
    begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        emit_cnt_next = emit_cnt_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        div_req.start    = 1'b0;
        div_req.dividend = emit_eff;
        div_req.divisor  = out_w;

        case (state_reg)
            ST_RUN:
            begin
                if (do_load && !frame_full)
                begin
                    load_cnt_next = load_cnt_reg + 1'b1;
                end
                else if (do_fetch && frame_full)
                begin
                    if (is_last)
                    begin
                        load_cnt_next = '0;
                        emit_cnt_next = '0;
                        row_next      = '0;
                        col_next      = '0;
                    end
                    else
                    begin
                        emit_cnt_next = emit_eff + 1'b1;
                        if (col_inc == out_w)
                        begin
                            col_next = '0;
                            row_next = row_reg + 1'b1;
                        end
                        else
                        begin
                            col_next = col_inc[POS_W-1:0];
                        end
                    end
                end
            end
            ST_DIV_LOAD:
            begin
                div_req.start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    row_next   = div_rsp.quot;
                    col_next   = div_rsp.rem;
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        // any register write (sizes, flip or rotation): rebuild row and column from the count
        if (cfg_wr)
        begin
            state_next = ST_DIV_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            load_cnt_reg  <= '0;
            emit_cnt_reg  <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            res_valid_reg <= 1'b0;
            res_early_reg <= 1'b0;
            res_last_reg  <= 1'b0;
            width_reg     <= DIM_W'(MAX_WIDTH);
            height_reg    <= DIM_W'(MAX_HEIGHT);
            flip_reg      <= 1'b0;
            rot_reg       <= ROT_NONE;
        end
        else
        begin
            state_reg     <= state_next;
            load_cnt_reg  <= load_cnt_next;
            emit_cnt_reg  <= emit_cnt_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            res_valid_reg <= do_fetch;
            res_early_reg <= do_fetch && !frame_full;
            res_last_reg  <= do_fetch && frame_full && is_last;
            if (cfg_wr)
            begin
                case (cfg_index)
                    CFG_WIDTH:    width_reg  <= cfg_data;
                    CFG_HEIGHT:   height_reg <= cfg_data;
                    CFG_FLIP:     flip_reg   <= cfg_data[0];
                    CFG_ROTATION: rot_reg    <= cfg_data[1:0];
                    default:      ;
                endcase
            end
        end
    end

    rfr_store u_store (
        .clk     (clk),
        .wr_en   (do_load && !frame_full),
        .wr_addr (load_cnt_reg[ADDR_W-1:0]),
        .wr_data (pixel_in),
        .rd_en   (do_fetch && frame_full),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rfr_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // early results carry a zero pixel
    assign result_valid = res_valid_reg;
    assign early        = res_early_reg;
    assign last_pixel   = res_last_reg;
    assign pixel_out    = res_early_reg ? '0 : rd_data;

endmodule

[rtl/rgb_frame_rotator_checker.sv]
`timescale 1ns / 1ps

module rgb_frame_rotator_checker
    import rfr_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             req_type,
    input logic             result_valid,
    input logic [PIX_W-1:0] pixel_out,
    input logic             last_pixel,
    input logic             early
);

    // every accepted fetch gives a word in the next cycle
    a_fetch_answered: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_FETCH) |=> result_valid)
        else $error("fetch without result");

    // no word appears without a fetch taken the cycle before
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy && req_type == REQ_FETCH))
        else $error("result without fetch");

    // an early word is never the end of a frame
    a_early_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(early && last_pixel))
        else $error("early and last together");

    // early words carry a zero pixel
    a_early_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && early) |-> (pixel_out == '0))
        else $error("early word with nonzero pixel");

endmodule

bind rgb_frame_rotator_unit rgb_frame_rotator_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .result_valid (result_valid),
    .pixel_out    (pixel_out),
    .last_pixel   (last_pixel),
    .early        (early)
);

[tb/tb_rgb_frame_rotator_unit.sv]
`timescale 1ns / 1ps

module tb_rgb_frame_rotator_unit;
    import rfr_pkg::*;

    // one result word as the block presents it
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
        logic             early;
    } pix_result_t;

    typedef enum logic [1:0] {ROW_LOAD, ROW_FETCH, ROW_CFG} row_kind_t;

    // one line of the opening script; want is only used where pin is set
    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [PIX_W-1:0]     data;
        bit                   pin;
        pix_result_t          want;
    } script_row_t;

    localparam pix_result_t EARLY_WORD = '{pixel: '0, last: 1'b0, early: 1'b1};
    localparam pix_result_t NO_WORD    = '0;
    localparam int RANDOM_WORDS = 1100;
    localparam int SCRIPT_LEN   = 28;

    // opening script: early fetch after reset, clamped 1x1 frame with a dropped load,
    // a 2x2 frame turned clockwise with flip, a rotation change mid-frame, a shrink
    // that pushes the fetch count past the frame so it starts over, then a
    // counter-clockwise 1x2 frame
    script_row_t opening_script [SCRIPT_LEN] = '{
        '{ROW_FETCH, CFG_WIDTH,    24'h000000, 1'b1, EARLY_WORD},
        '{ROW_CFG,   CFG_WIDTH,    24'd0,      1'b0, NO_WORD},
        '{ROW_CFG,   CFG_HEIGHT,   24'd0,      1'b0, NO_WORD},
        '{ROW_LOAD,  CFG_WIDTH,    24'hFFFFFF, 1'b0, NO_WORD},
        '{ROW_LOAD,  CFG_WIDTH,    24'h000000, 1'b0, NO_WORD},
        '{ROW_FETCH, CFG_WIDTH,    24'h000000, 1'b1, '{24'hFFFFFF, 1'b1, 1'b0}},
        '{ROW_FETCH, CFG_WIDTH,    24'h000000, 1'b1, EARLY_WORD},
        '{ROW_CFG,   CFG_WIDTH,    24'd2,      1'b0, NO_WORD},
        '{ROW_CFG,   CFG_HEIGHT,   24'd2,      1'b0, NO_WORD},
        '{ROW_CFG,   CFG_FLIP,     24'd1,      1'b0, NO_WORD},
        '{ROW_CFG,   CFG_ROTATION, 24'(ROT_CW), 1'b0, NO_WORD},
        '{ROW_LOAD,  CFG_WIDTH,    24'h000001, 1'b0, NO_WORD},
        '{ROW_LOAD,  CFG_WIDTH,    24'h800000, 1'b0, NO_WORD},
        '{ROW_LOAD,  CFG_WIDTH,    24'h5A5A5A, 1'b0, NO_WORD},
        '{ROW_LOAD,  CFG_WIDTH,    24'hA5A5A5, 1'b0, NO_WORD},
        '{ROW_FETCH, CFG_WIDTH,    24'h000000, 1'b0, NO_WORD},
        '{ROW_FETCH, CFG_WIDTH,    24'h000000, 1'b0, NO_WORD},
        '{ROW_CFG,   CFG_ROTATION, 24'(ROT_HALF), 1'b0, NO_WORD},
        '{ROW_FETCH, CFG_WIDTH,    24'h000000, 1'b0, NO_WORD},
        '{ROW_CFG,   CFG_WIDTH,    24'd1,      1'b0, NO_WORD},
        '{ROW_FETCH, CFG_WIDTH,    24'h000000, 1'b0, NO_WORD},
        '{ROW_FETCH, CFG_WIDTH,    24'h000000, 1'b0, NO_WORD},
        '{ROW_CFG,   CFG_ROTATION, 24'(ROT_CCW), 1'b0, NO_WORD},
        '{ROW_LOAD,  CFG_WIDTH,    24'h123456, 1'b0, NO_WORD},
        '{ROW_LOAD,  CFG_WIDTH,    24'hFEDCBA, 1'b0, NO_WORD},
        '{ROW_FETCH, CFG_WIDTH,    24'h000000, 1'b0, NO_WORD},
        '{ROW_FETCH, CFG_WIDTH,    24'h000000, 1'b0, NO_WORD},
        '{ROW_CFG,   CFG_ROTATION, 24'(ROT_NONE), 1'b0, NO_WORD}
    };

    // dut ports
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 req_type = REQ_LOAD;
    logic [PIX_W-1:0]     pixel_in = '0;
    logic                 result_valid;
    logic [PIX_W-1:0]     pixel_out;
    logic                 last_pixel;
    logic                 early;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_WIDTH;
    logic [DIM_W-1:0]     cfg_data = '0;

    // side info riding along with the word on the input channel
    bit          pin_use = 1'b0;
    pix_result_t pin_want = NO_WORD;

    // shadow of the rotator: frame store, counters and registers
    logic [PIX_W-1:0] frame_mem [STORE_DEPTH];
    int               loaded = 0;
    int               emitted = 0;
    logic [DIM_W-1:0] reg_width = 7'd64;
    logic [DIM_W-1:0] reg_height = 7'd64;
    logic             reg_flip = 1'b0;
    logic [1:0]       reg_rot = ROT_NONE;

    // output words still owed by the block, oldest first
    pix_result_t pending_pixels [$];

    // bookkeeping
    int          fail_count = 0;
    int          stored_cnt = 0;
    int          dropped_cnt = 0;
    int          fetch_cnt = 0;
    int          early_cnt = 0;
    int          frame_cnt = 0;
    int          cfg_cnt = 0;
    logic [3:0]  rot_seen = '0;
    int          prev_loaded;
    bit          owed;
    pix_result_t calc;
    pix_result_t want;

    rgb_frame_rotator_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .pixel_in     (pixel_in),
        .result_valid (result_valid),
        .pixel_out    (pixel_out),
        .last_pixel   (last_pixel),
        .early        (early),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int hi);
        if (v == 0)
            return 1;
        if (int'(v) > hi)
            return hi;
        return int'(v);
    endfunction

    // advance the shadow by one accepted word; returns 1 when a result word is owed
    function automatic bit predict_word(input logic req, input logic [PIX_W-1:0] pix,
                                        output pix_result_t res);
        int w, h, total, e, ow, r, c, sy, sx, addr;
        w = clamp_dim(reg_width, MAX_WIDTH);
        h = clamp_dim(reg_height, MAX_HEIGHT);
        total = w * h;
        res = NO_WORD;
        if (req == REQ_LOAD)
        begin
            // loads past a full frame fall on the floor
            if (loaded < total && loaded < STORE_DEPTH)
            begin
                frame_mem[loaded] = pix;
                loaded++;
            end
            return 1'b0;
        end
        // fetch before the frame is complete: flagged, nothing moves
        if (loaded < total)
        begin
            res.early = 1'b1;
            return 1'b1;
        end
        // a shrink can leave the fetch count past the frame: start over
        e = (emitted < total) ? emitted : 0;
        ow = (reg_rot == ROT_CW || reg_rot == ROT_CCW) ? h : w;
        r = e / ow;
        c = e % ow;
        case (reg_rot)
            ROT_CW:
            begin
                sy = h - 1 - c;
                sx = r;
            end
            ROT_HALF:
            begin
                sy = h - 1 - r;
                sx = w - 1 - c;
            end
            ROT_CCW:
            begin
                sy = c;
                sx = w - 1 - r;
            end
            default:
            begin
                sy = r;
                sx = c;
            end
        endcase
        // flip applies to the source before the turn
        if (reg_flip)
            sy = h - 1 - sy;
        addr = sy * w + sx;
        res.pixel = (addr < STORE_DEPTH) ? frame_mem[addr] : '0;
        // last pixel of the output frame clears both counters
        if (e + 1 >= total)
        begin
            res.last = 1'b1;
            loaded = 0;
            emitted = 0;
        end
        else
            emitted = e + 1;
        return 1'b1;
    endfunction

    // scoreboard: results first (they belong to older words), then new words,
    // then register writes, all on pre-edge values
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (pending_pixels.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: result word with nothing owed: pixel %06h last %0b early %0b",
                                 $realtime, pixel_out, last_pixel, early);
                    fail_count++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (pixel_out !== want.pixel || last_pixel !== want.last ||
                        early !== want.early)
                    begin
                        if (fail_count < 10)
                            $display("%0t: mismatch: pixel %06h/%06h last %0b/%0b early %0b/%0b",
                                     $realtime, pixel_out, want.pixel, last_pixel, want.last,
                                     early, want.early);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                prev_loaded = loaded;
                if (req_type == REQ_FETCH)
                    rot_seen[reg_rot] = 1'b1;
                owed = predict_word(req_type, pixel_in, calc);
                if (owed)
                begin
                    pending_pixels.push_back(pin_use ? pin_want : calc);
                    fetch_cnt++;
                    if (calc.early)
                        early_cnt++;
                    if (calc.last)
                        frame_cnt++;
                end
                else if (loaded != prev_loaded)
                    stored_cnt++;
                else
                    dropped_cnt++;
            end
            if (cfg_valid && cfg_ready)
            begin
                cfg_cnt++;
                case (cfg_index)
                    CFG_WIDTH:    reg_width = cfg_data;
                    CFG_HEIGHT:   reg_height = cfg_data;
                    CFG_FLIP:     reg_flip = cfg_data[0];
                    CFG_ROTATION: reg_rot = cfg_data[1:0];
                    default:      ;
                endcase
            end
        end
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // put one word on the input channel and hold it until taken
    task automatic send_word(input logic req, input logic [PIX_W-1:0] pix, input bit pin,
                             input pix_result_t pinned, input bit quiet);
        int gap;
        gap = quiet ? 0 : idle_len();
        cfg_valid <= 1'b0;
        if (gap > 0)
        begin
            start <= 1'b0;
            req_type <= 1'($urandom);
            pixel_in <= PIX_W'($urandom);
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req_type <= req;
        pixel_in <= pix;
        pin_use <= pin;
        pin_want <= pinned;
        do @(posedge clk); while (busy);
    endtask

    // register write; valid stays up so writes can run back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // stop sending and wait until every owed word has come back, plus a margin
    // for loads still in flight
    task automatic drain();
        start <= 1'b0;
        cfg_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int          phase, style, total, have, done_px, n, k, sel;
        int          w, h;
        logic [DIM_W-1:0] wv, hv;
        bit          quiet, all_regs;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // opening script
        for (k = 0; k < SCRIPT_LEN; k++)
        begin
            case (opening_script[k].kind)
                ROW_CFG:
                begin
                    if (k == 0 || opening_script[k - 1].kind != ROW_CFG)
                        drain();
                    write_reg(opening_script[k].idx, opening_script[k].data[DIM_W-1:0]);
                end
                ROW_LOAD:
                    send_word(REQ_LOAD, opening_script[k].data, 1'b0, NO_WORD, 1'b0);
                default:
                    send_word(REQ_FETCH, PIX_W'($urandom), opening_script[k].pin,
                              opening_script[k].want, 1'b0);
            endcase
        end

        // random phases: each one settles, rewrites some registers, then runs a frame, part of one, or noise
        phase = 0;
        drain();
        while (stored_cnt + fetch_cnt < RANDOM_WORDS + 20)
        begin
            all_regs = (phase == 0) || ($urandom_range(0, 3) == 0);
            // sizes always change together so two large sides never meet
            if (all_regs || $urandom_range(0, 1) == 1)
            begin
                sel = $urandom_range(0, 11);
                case (sel)
                    0:
                    begin
                        wv = $urandom_range(0, 1) ? 7'd127 : 7'd64;
                        hv = DIM_W'($urandom_range(1, 2));
                    end
                    1:
                    begin
                        wv = DIM_W'($urandom_range(1, 2));
                        hv = $urandom_range(0, 1) ? 7'd127 : 7'd64;
                    end
                    2:
                    begin
                        wv = 7'd0;
                        hv = DIM_W'($urandom_range(0, 5));
                    end
                    3:
                    begin
                        wv = DIM_W'($urandom_range(0, 5));
                        hv = 7'd0;
                    end
                    default:
                    begin
                        wv = DIM_W'($urandom_range(1, 8));
                        hv = DIM_W'($urandom_range(1, 8));
                    end
                endcase
                write_reg(CFG_WIDTH, wv);
                write_reg(CFG_HEIGHT, hv);
            end
            // upper bits of flip and rotation data are don't-care, toggle them anyway
            if (all_regs || $urandom_range(0, 1) == 1)
                write_reg(CFG_FLIP, DIM_W'($urandom_range(0, 127)));
            if (all_regs || $urandom_range(0, 1) == 1)
                write_reg(CFG_ROTATION, DIM_W'($urandom_range(0, 127)));
            cfg_valid <= 1'b0;
            @(posedge clk);

            // shadow is settled here, size the frame from it
            w = clamp_dim(reg_width, MAX_WIDTH);
            h = clamp_dim(reg_height, MAX_HEIGHT);
            total = w * h;
            have = loaded;
            done_px = (emitted < total) ? emitted : 0;
            style = $urandom_range(0, 9);
            quiet = ($urandom_range(0, 3) == 0);

            if (style <= 6)
            begin
                // well-formed frame with the odd early fetch while loading
                for (k = have; k < total; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_word(REQ_FETCH, PIX_W'($urandom), 1'b0, NO_WORD, quiet);
                    send_word(REQ_LOAD, PIX_W'($urandom), 1'b0, NO_WORD, quiet);
                end
                // loads into a full frame
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 2))
                        send_word(REQ_LOAD, PIX_W'($urandom), 1'b0, NO_WORD, quiet);
                for (k = done_px; k < total; k++)
                    send_word(REQ_FETCH, PIX_W'($urandom), 1'b0, NO_WORD, quiet);
            end
            else if (style == 7)
            begin
                // frame cut short while loading; fetches before the frame is full come back early
                n = $urandom_range(0, total - 1);
                for (k = 0; k < n; k++)
                begin
                    if ($urandom_range(0, 2) == 0)
                        send_word(REQ_FETCH, PIX_W'($urandom), 1'b0, NO_WORD, quiet);
                    send_word(REQ_LOAD, PIX_W'($urandom), 1'b0, NO_WORD, quiet);
                end
            end
            else if (style == 8)
            begin
                // full load, partial readout: next phase may reconfigure mid-frame
                for (k = have; k < total; k++)
                    send_word(REQ_LOAD, PIX_W'($urandom), 1'b0, NO_WORD, quiet);
                n = $urandom_range(1, (total > 1) ? total - 1 : 1);
                for (k = 0; k < n; k++)
                    send_word(REQ_FETCH, PIX_W'($urandom), 1'b0, NO_WORD, quiet);
            end
            else
            begin
                // noise: any mix of loads and fetches
                n = $urandom_range(4, 16);
                for (k = 0; k < n; k++)
                    send_word(1'($urandom), PIX_W'($urandom), 1'b0, NO_WORD, quiet);
            end

            // sender holds off until everything owed has arrived
            drain();
            phase++;
        end

        drain();
        repeat (8) @(posedge clk);
        if (pending_pixels.size() != 0)
        begin
            $display("%0d result words never arrived", pending_pixels.size());
            fail_count++;
        end

        $display("run: %0d phases, %0d pixels stored, %0d loads dropped, %0d register writes",
                 phase, stored_cnt, dropped_cnt, cfg_cnt);
        $display("run: %0d fetches, %0d early, %0d frames read out, rotations seen %4b",
                 fetch_cnt, early_cnt, frame_cnt, rot_seen);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // hard stop far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
